FILE: design/indexed_insert_delete_list_top_defines.svh
// Assertion macros shared by the list block's assertion section.
`ifndef INDEXED_INSERT_DELETE_LIST_TOP_DEFINES_SVH
`define INDEXED_INSERT_DELETE_LIST_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define IIDL_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("list block assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define IIDL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("list block assertion failed");

`endif

FILE: design/iidl_pkg.sv
// Types and constants of the indexed insert/delete list.
package iidl_pkg;

    localparam int CNT_W  = 7;
    localparam int DATA_W = 32;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_DUMP   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic [CNT_W-1:0]        index;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [1:0]              status;
        logic [CNT_W-1:0]        count;
        logic                    last;
    } t_out_item;

endpackage

FILE: design/iidl_store.sv
// Entry store of the list: one write port and one registered read port.
module iidl_store
    import iidl_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic signed [DATA_W-1:0] i_wdata,
    input  logic                     i_re,
    input  logic [AW-1:0]            i_raddr,
    output logic signed [DATA_W-1:0] o_rdata
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/iidl_ctrl.sv
// Sequencer of the list: decodes an item, walks the shift or dump one entry at a time.
module iidl_ctrl
    import iidl_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int AW       = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  t_in_item                 i_item,
    output logic                     o_busy,
    output logic                     o_we,
    output logic [AW-1:0]            o_waddr,
    output logic signed [DATA_W-1:0] o_wdata,
    output logic                     o_re,
    output logic [AW-1:0]            o_raddr,
    input  logic signed [DATA_W-1:0] i_rdata,
    output logic                     o_strobe,
    output t_out_item                o_result
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_INS_SH  = 7'b0000010,
        S_INS_WR  = 7'b0000100,
        S_DEL_SH  = 7'b0001000,
        S_DEL_WR  = 7'b0010000,
        S_DMP_RD  = 7'b0100000,
        S_DMP_OUT = 7'b1000000
    } t_state;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_i, n_i;
    logic [CNT_W-1:0]         r_pos, n_pos;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic                     r_strobe, n_strobe;
    t_out_item                r_res, n_res;
    logic [CNT_W-1:0]         w_im1, w_ip1;

    assign w_im1 = r_i - ONE;
    assign w_ip1 = r_i + ONE;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_i      = r_i;
        n_pos    = r_pos;
        n_val    = r_val;
        n_strobe = 1'b0;
        n_res    = r_res;
        o_we     = 1'b0;
        o_waddr  = r_i[AW-1:0];
        o_wdata  = i_rdata;
        o_re     = 1'b0;
        o_raddr  = r_i[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_pos    = i_item.index;
                    n_val    = i_item.value;
                    n_strobe = 1'b1;
                    n_res    = '{data: '0, status: ST_OK, count: r_count, last: 1'b1};
                    priority if (i_item.kind == KIND_INSERT) begin
                        priority if (r_count >= CAP_CNT) begin
                            n_res.status = ST_FULL;
                        end else if (i_item.index > r_count) begin
                            n_res.status = ST_RANGE;
                        end else begin
                            n_strobe = 1'b0;
                            n_i      = r_count;
                            n_state  = S_INS_SH;
                        end
                    end else if (i_item.kind == KIND_DELETE) begin
                        priority if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                        end else if (i_item.index >= r_count) begin
                            n_res.status = ST_RANGE;
                        end else begin
                            n_strobe = 1'b0;
                            n_i      = i_item.index;
                            n_state  = S_DEL_SH;
                        end
                    end else if (i_item.kind == KIND_DUMP) begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            n_strobe = 1'b0;
                            n_i      = '0;
                            n_state  = S_DMP_RD;
                        end
                    end else begin
                        // Unused kind: plain acknowledge, nothing changes.
                        n_res.status = ST_OK;
                    end
                end
            end
            S_INS_SH: begin
                if (r_i > r_pos) begin
                    o_re    = 1'b1;
                    o_raddr = w_im1[AW-1:0];
                    n_state = S_INS_WR;
                end else begin
                    o_we     = 1'b1;
                    o_waddr  = r_pos[AW-1:0];
                    o_wdata  = r_val;
                    n_count  = r_count + ONE;
                    n_strobe = 1'b1;
                    n_res    = '{data: '0, status: ST_OK, count: n_count, last: 1'b1};
                    n_state  = S_IDLE;
                end
            end
            S_INS_WR: begin
                o_we    = 1'b1;
                n_i     = w_im1;
                n_state = S_INS_SH;
            end
            S_DEL_SH: begin
                if (w_ip1 < r_count) begin
                    o_re    = 1'b1;
                    o_raddr = w_ip1[AW-1:0];
                    n_state = S_DEL_WR;
                end else begin
                    n_count  = r_count - ONE;
                    n_strobe = 1'b1;
                    n_res    = '{data: '0, status: ST_OK, count: n_count, last: 1'b1};
                    n_state  = S_IDLE;
                end
            end
            S_DEL_WR: begin
                o_we    = 1'b1;
                n_i     = w_ip1;
                n_state = S_DEL_SH;
            end
            S_DMP_RD: begin
                o_re    = 1'b1;
                n_state = S_DMP_OUT;
            end
            S_DMP_OUT: begin
                n_strobe = 1'b1;
                n_res    = '{data: i_rdata, status: ST_OK, count: r_count,
                             last: (w_ip1 == r_count)};
                n_i      = w_ip1;
                n_state  = (w_ip1 == r_count) ? S_IDLE : S_DMP_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i   <= n_i;
        r_pos <= n_pos;
        r_val <= n_val;
        r_res <= n_res;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

FILE: design/indexed_insert_delete_list_top.sv
// Top level of the indexed insert/delete list: sequencer, entry store and checks.
//
// An item (kind, index, value) is accepted at a clock edge where start is high
// and busy is low. Every item yields one or more results, each shown on o_result
// for exactly one cycle while o_strobe is high; the receiver cannot hold them off.
// The last result of an item carries last = 1.
//
// Refused operations (full, empty, index out of range) and unused kinds answer
// in the cycle after acceptance and never raise busy, so a new item may follow
// at once. An insert at position p with n entries held moves n - p entries, each
// read, then written through the store, whose read port is registered; then it
// writes the new value and answers. A delete at p moves n - p - 1 entries the
// same way. A dump streams the entries one at a time, each read through the
// store's registered read port and then put out; an empty dump answers at once.
// Busy stays high from acceptance until the final result is registered.
//
// Reset clears the entry count and the sequencer; the store itself keeps
// whatever it held, since only entries below the count are ever read.
module indexed_insert_delete_list_top
    import iidl_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result
);

`include "indexed_insert_delete_list_top_defines.svh"

    localparam int AW = $clog2(CAPACITY);

    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic signed [DATA_W-1:0] w_wdata;
    logic                     w_re;
    logic [AW-1:0]            w_raddr;
    logic signed [DATA_W-1:0] w_rdata;

    // The sequencer owns the count and every decision; the store only holds words.
    iidl_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .o_busy   (busy),
        .o_we     (w_we),
        .o_waddr  (w_waddr),
        .o_wdata  (w_wdata),
        .o_re     (w_re),
        .o_raddr  (w_raddr),
        .i_rdata  (w_rdata),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    iidl_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // A full refusal can only happen with the store at capacity.
    `IIDL_ASSERT_IMPLY(a_full_count, o_strobe && o_result.status == ST_FULL, o_result.count == CNT_W'(CAPACITY))
    // An empty refusal or empty dump reports a zero count.
    `IIDL_ASSERT_IMPLY(a_empty_count, o_strobe && o_result.status == ST_EMPTY, o_result.count == '0)
    // Only a dump entry carries data; every refusal reports zero data and is the last result.
    `IIDL_ASSERT_IMPLY(a_refused_data, o_strobe && o_result.status != ST_OK, o_result.data == '0 && o_result.last)
    // A dump result that is not the final one leaves the block busy fetching the next entry.
    `IIDL_ASSERT_NEXT(a_dump_continues, o_strobe && !o_result.last, busy && !o_strobe)

endmodule
